>>> hw/rtl/ssf_pkg.sv
`default_nettype none
package ssf_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int PIX_W       = 32;
	localparam int X_W         = 8;
	localparam int Y_W         = 8;
	localparam int CFG_W       = 9;
	localparam int CRD_W       = 10;
	localparam int PIX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int STACK_DEPTH = 1024;
	localparam int SA_W        = 10;
	localparam int SP_W        = 11;
	localparam int SEG_W       = 25;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd32;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd32;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_NONE  = 2'd3
	} ssf_code_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} ssf_reg_t;

	typedef enum logic [1:0] {
		XOP_HOLD,
		XOP_INC,
		XOP_DEC,
		XOP_LDL1
	} ssf_xop_t;

	typedef enum logic [1:0] {
		ST_HOLD,
		ST_XP1,
		ST_X
	} ssf_stop_t;

	typedef enum logic [2:0] {
		PS_SEED_DN,
		PS_SEED_UP,
		PS_LEAK_L,
		PS_SPAN,
		PS_LEAK_R
	} ssf_psrc_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_READ,
		RES_FILL
	} ssf_res_t;

	typedef struct packed {
		logic      ld_item;
		logic      rd_cur;
		logic      wr_item;
		logic      wr_fill;
		ssf_xop_t  xop;
		ssf_stop_t stop;
		logic      push;
		ssf_psrc_t psrc;
		logic      pop;
		logic      ld_seg;
		logic      ld_ov;
		logic      sp_clr;
		logic      set_ovf;
		logic      res_ld;
		ssf_res_t  res;
	} ssf_cmd_t;

	typedef struct packed {
		ssf_code_t code;
		logic      in_img;
		logic      seed_same;
		logic      pix_eq;
		logic      x_neg;
		logic      x_lt_w;
		logic      x_le_r;
		logic      x_ge_l;
		logic      start_lt_l;
		logic      x_gt_r1;
		logic      push_ovf;
		logic      sp_zero;
	} ssf_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssf_ram.sv
`default_nettype none
module ssf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/ssf_dp.sv
`default_nettype none
module ssf_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [0:0]                   cfg_index,
	input  wire logic [ssf_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [1:0]                   command,
	input  wire logic [ssf_pkg::X_W-1:0]      pos_x,
	input  wire logic [ssf_pkg::Y_W-1:0]      pos_y,
	input  wire logic [ssf_pkg::PIX_W-1:0]    pixel_value,
	input  wire ssf_pkg::ssf_cmd_t            cmd,
	output ssf_pkg::ssf_sts_t                 sts,
	output logic      [ssf_pkg::PIX_W-1:0]    read_value,
	output logic      [ssf_pkg::X_W-1:0]      box_left,
	output logic      [ssf_pkg::Y_W-1:0]      box_top,
	output logic      [ssf_pkg::X_W-1:0]      box_right,
	output logic      [ssf_pkg::Y_W-1:0]      box_bottom,
	output logic                              box_empty,
	output logic                              stack_overflow
);
	localparam int PA_W = ssf_pkg::X_W + ssf_pkg::Y_W;

	logic [ssf_pkg::CFG_W-1:0] width_q, height_q, eff_w, eff_h;
	logic [ssf_pkg::X_W-1:0]   sx_q, l_q, r_q, bl_q, br_q;
	logic [ssf_pkg::Y_W-1:0]   sy_q, cy_q, bt_q, bb_q;
	logic [ssf_pkg::PIX_W-1:0] pen_q, ov_q, pix_rdata;
	logic signed [ssf_pkg::CRD_W-1:0] cx_q, start_q, l_s, r_s, w_s;
	logic signed [ssf_pkg::CRD_W-1:0] py, pxl, pxr, ny;
	logic                      dn_q, pdn, in_rng, any_q, ovf_q, inside_q;
	logic [ssf_pkg::SP_W-1:0]  sp_q;
	logic [ssf_pkg::SEG_W-1:0] seg_rdata;
	logic                      stk_we, pix_we;
	logic [PA_W-1:0]           pix_waddr, pix_raddr;
	logic [ssf_pkg::PIX_W-1:0] pix_wdata;

	// clamp configured size into 1..max
	always_comb begin
		if (width_q == '0) eff_w = ssf_pkg::CFG_W'(1);
		else if (width_q > ssf_pkg::CFG_W'(ssf_pkg::MAX_WIDTH))
			eff_w = ssf_pkg::CFG_W'(ssf_pkg::MAX_WIDTH);
		else eff_w = width_q;
		if (height_q == '0) eff_h = ssf_pkg::CFG_W'(1);
		else if (height_q > ssf_pkg::CFG_W'(ssf_pkg::MAX_HEIGHT))
			eff_h = ssf_pkg::CFG_W'(ssf_pkg::MAX_HEIGHT);
		else eff_h = height_q;
	end

	assign l_s = $signed({2'b00, l_q});
	assign r_s = $signed({2'b00, r_q});
	assign w_s = $signed({1'b0, eff_w});

	// segment push operands
	always_comb begin
		case (cmd.psrc)
			ssf_pkg::PS_SEED_DN: begin
				py = $signed({2'b00, sy_q}); pdn = 1'b0;
				pxl = $signed({2'b00, sx_q}); pxr = pxl;
			end
			ssf_pkg::PS_SEED_UP: begin
				py = $signed({2'b00, sy_q}) + 10'sd1; pdn = 1'b1;
				pxl = $signed({2'b00, sx_q}); pxr = pxl;
			end
			ssf_pkg::PS_LEAK_L: begin
				py = $signed({2'b00, cy_q}); pdn = ~dn_q;
				pxl = cx_q + 10'sd1; pxr = l_s - 10'sd1;
			end
			ssf_pkg::PS_SPAN: begin
				py = $signed({2'b00, cy_q}); pdn = dn_q;
				pxl = start_q; pxr = cx_q - 10'sd1;
			end
			ssf_pkg::PS_LEAK_R: begin
				py = $signed({2'b00, cy_q}); pdn = ~dn_q;
				pxl = r_s + 10'sd1; pxr = cx_q - 10'sd1;
			end
			default: begin
				py = '0; pdn = 1'b0; pxl = '0; pxr = '0;
			end
		endcase
		ny = pdn ? py - 10'sd1 : py + 10'sd1;
		in_rng = !ny[ssf_pkg::CRD_W-1] && (ny < $signed({1'b0, eff_h}));
	end

	assign stk_we = cmd.push && in_rng && (sp_q != ssf_pkg::SP_W'(ssf_pkg::STACK_DEPTH));

	ssf_ram #(.WIDTH(ssf_pkg::SEG_W), .DEPTH(ssf_pkg::STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_q[ssf_pkg::SA_W-1:0]),
		.wdata ({ny[ssf_pkg::Y_W-1:0], pxl[ssf_pkg::X_W-1:0], pxr[ssf_pkg::X_W-1:0], pdn}),
		.raddr (sp_q[ssf_pkg::SA_W-1:0] - ssf_pkg::SA_W'(1)),
		.rdata (seg_rdata)
	);

	assign pix_we    = (cmd.wr_item && sts.in_img) || cmd.wr_fill;
	assign pix_waddr = cmd.wr_fill ? {cy_q, cx_q[ssf_pkg::X_W-1:0]} : {pos_y, pos_x};
	assign pix_wdata = cmd.wr_fill ? pen_q : pixel_value;
	assign pix_raddr = cmd.rd_cur ? {cy_q, cx_q[ssf_pkg::X_W-1:0]} : {pos_y, pos_x};

	ssf_ram #(.WIDTH(ssf_pkg::PIX_W), .DEPTH(ssf_pkg::PIX_DEPTH)) u_pix (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (pix_wdata),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	always_comb begin
		sts.code       = ssf_pkg::ssf_code_t'(command);
		sts.in_img     = ({1'b0, pos_x} < eff_w) && ({1'b0, pos_y} < eff_h);
		sts.seed_same  = (pix_rdata == pen_q);
		sts.pix_eq     = (pix_rdata == ov_q);
		sts.x_neg      = cx_q[ssf_pkg::CRD_W-1];
		sts.x_lt_w     = (cx_q < w_s);
		sts.x_le_r     = (cx_q <= r_s);
		sts.x_ge_l     = (cx_q >= l_s);
		sts.start_lt_l = (cx_q + 10'sd1 < l_s);
		sts.x_gt_r1    = (cx_q > r_s + 10'sd1);
		sts.push_ovf   = in_rng && (sp_q == ssf_pkg::SP_W'(ssf_pkg::STACK_DEPTH));
		sts.sp_zero    = (sp_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ssf_pkg::WIDTH_RST;
			height_q <= ssf_pkg::HEIGHT_RST;
			sp_q     <= '0;
			any_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (ssf_pkg::ssf_reg_t'(cfg_index))
					ssf_pkg::REG_WIDTH:  width_q  <= cfg_data;
					ssf_pkg::REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.sp_clr) sp_q <= '0;
			else if (stk_we) sp_q <= sp_q + ssf_pkg::SP_W'(1);
			else if (cmd.pop) sp_q <= sp_q - ssf_pkg::SP_W'(1);
			if (cmd.ld_item) begin
				any_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.wr_fill) any_q <= 1'b1;
				if (cmd.set_ovf) ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			sx_q     <= pos_x;
			sy_q     <= pos_y;
			pen_q    <= pixel_value;
			inside_q <= sts.in_img;
		end
		if (cmd.ld_ov) ov_q <= pix_rdata;
		if (cmd.ld_seg) begin
			cy_q <= seg_rdata[24:17];
			l_q  <= seg_rdata[16:9];
			r_q  <= seg_rdata[8:1];
			dn_q <= seg_rdata[0];
			cx_q <= $signed({2'b00, seg_rdata[16:9]});
		end else begin
			case (cmd.xop)
				ssf_pkg::XOP_INC:  cx_q <= cx_q + 10'sd1;
				ssf_pkg::XOP_DEC:  cx_q <= cx_q - 10'sd1;
				ssf_pkg::XOP_LDL1: cx_q <= l_s + 10'sd1;
				default: ;
			endcase
		end
		case (cmd.stop)
			ssf_pkg::ST_XP1: start_q <= cx_q + 10'sd1;
			ssf_pkg::ST_X:   start_q <= cx_q;
			default: ;
		endcase
		if (cmd.wr_fill) begin
			if (!any_q || cx_q[ssf_pkg::X_W-1:0] < bl_q) bl_q <= cx_q[ssf_pkg::X_W-1:0];
			if (!any_q || cx_q[ssf_pkg::X_W-1:0] > br_q) br_q <= cx_q[ssf_pkg::X_W-1:0];
			if (!any_q || cy_q < bt_q) bt_q <= cy_q;
			if (!any_q || cy_q > bb_q) bb_q <= cy_q;
		end
		if (cmd.res_ld) begin
			read_value     <= '0;
			box_left       <= '0;
			box_top        <= '0;
			box_right      <= '0;
			box_bottom     <= '0;
			box_empty      <= 1'b1;
			stack_overflow <= 1'b0;
			case (cmd.res)
				ssf_pkg::RES_READ: read_value <= inside_q ? pix_rdata : '0;
				ssf_pkg::RES_FILL: begin
					stack_overflow <= ovf_q;
					if (any_q) begin
						box_left   <= bl_q;
						box_top    <= bt_q;
						box_right  <= br_q;
						box_bottom <= bb_q;
						box_empty  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/ssf_ctrl.sv
`default_nettype none
module ssf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire ssf_pkg::ssf_sts_t sts,
	output ssf_pkg::ssf_cmd_t      cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_SEED, S_PA, S_PB, S_POP, S_POPW,
		S_LRD, S_LCK, S_LEND, S_RRD, S_RCK, S_REND, S_REND2,
		S_INC, S_SRD, S_SCK, S_SEND, S_DONE
	} state_t;

	state_t state_q, nxt;
	logic   in_acc;

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		case (state_q)
			S_IDLE: if (in_acc) begin
				cmd.ld_item = 1'b1;
				case (sts.code)
					ssf_pkg::CMD_WRITE: begin
						cmd.wr_item = 1'b1;
						cmd.res_ld  = 1'b1;
						cmd.res     = ssf_pkg::RES_ZERO;
					end
					ssf_pkg::CMD_READ: begin
						nxt = S_RD;
					end
					ssf_pkg::CMD_FILL: begin
						if (sts.in_img) begin
							nxt = S_SEED;
						end else begin
							cmd.res_ld = 1'b1;
							cmd.res    = ssf_pkg::RES_ZERO;
						end
					end
					default: begin
						cmd.res_ld = 1'b1;
						cmd.res    = ssf_pkg::RES_ZERO;
					end
				endcase
			end
			S_RD: begin
				cmd.res_ld = 1'b1;
				cmd.res    = ssf_pkg::RES_READ;
				nxt = S_IDLE;
			end
			S_SEED: begin
				cmd.ld_ov  = 1'b1;
				cmd.sp_clr = 1'b1;
				nxt = sts.seed_same ? S_DONE : S_PA;
			end
			S_PA: begin
				cmd.push = 1'b1;
				cmd.psrc = ssf_pkg::PS_SEED_DN;
				cmd.set_ovf = sts.push_ovf;
				nxt = sts.push_ovf ? S_DONE : S_PB;
			end
			S_PB: begin
				cmd.push = 1'b1;
				cmd.psrc = ssf_pkg::PS_SEED_UP;
				cmd.set_ovf = sts.push_ovf;
				nxt = sts.push_ovf ? S_DONE : S_POP;
			end
			S_POP: begin
				if (sts.sp_zero) nxt = S_DONE;
				else begin
					cmd.pop = 1'b1;
					nxt = S_POPW;
				end
			end
			S_POPW: begin
				cmd.ld_seg = 1'b1;
				nxt = S_LRD;
			end
			S_LRD: begin
				if (sts.x_neg) nxt = S_LEND;
				else begin
					cmd.rd_cur = 1'b1;
					nxt = S_LCK;
				end
			end
			S_LCK: begin
				if (sts.pix_eq) begin
					cmd.wr_fill = 1'b1;
					cmd.xop = ssf_pkg::XOP_DEC;
					nxt = S_LRD;
				end else nxt = S_LEND;
			end
			S_LEND: begin
				if (sts.x_ge_l) nxt = S_INC;
				else begin
					cmd.stop = ssf_pkg::ST_XP1;
					cmd.xop  = ssf_pkg::XOP_LDL1;
					cmd.psrc = ssf_pkg::PS_LEAK_L;
					cmd.push = sts.start_lt_l;
					cmd.set_ovf = sts.start_lt_l && sts.push_ovf;
					nxt = (sts.start_lt_l && sts.push_ovf) ? S_DONE : S_RRD;
				end
			end
			S_RRD: begin
				if (sts.x_lt_w) begin
					cmd.rd_cur = 1'b1;
					nxt = S_RCK;
				end else nxt = S_REND;
			end
			S_RCK: begin
				if (sts.pix_eq) begin
					cmd.wr_fill = 1'b1;
					cmd.xop = ssf_pkg::XOP_INC;
					nxt = S_RRD;
				end else nxt = S_REND;
			end
			S_REND: begin
				cmd.push = 1'b1;
				cmd.psrc = ssf_pkg::PS_SPAN;
				cmd.set_ovf = sts.push_ovf;
				nxt = sts.push_ovf ? S_DONE : S_REND2;
			end
			S_REND2: begin
				cmd.psrc = ssf_pkg::PS_LEAK_R;
				cmd.push = sts.x_gt_r1;
				cmd.set_ovf = sts.x_gt_r1 && sts.push_ovf;
				nxt = (sts.x_gt_r1 && sts.push_ovf) ? S_DONE : S_INC;
			end
			S_INC: begin
				cmd.xop = ssf_pkg::XOP_INC;
				nxt = S_SRD;
			end
			S_SRD: begin
				if (sts.x_le_r) begin
					cmd.rd_cur = 1'b1;
					nxt = S_SCK;
				end else nxt = S_SEND;
			end
			S_SCK: begin
				if (!sts.pix_eq) begin
					cmd.xop = ssf_pkg::XOP_INC;
					nxt = S_SRD;
				end else nxt = S_SEND;
			end
			S_SEND: begin
				cmd.stop = ssf_pkg::ST_X;
				nxt = sts.x_le_r ? S_RRD : S_POP;
			end
			S_DONE: begin
				cmd.res_ld = 1'b1;
				cmd.res    = ssf_pkg::RES_FILL;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.res_ld) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/scanline_seed_fill.sv
// scanline seed fill engine over a 256 x 256 image of 32-bit pixels
// input channel: in_valid / in_stall, one beat per command (write, read, fill)
// output channel: out_valid / out_stall, exactly one result beat per command
// config: cfg_we with cfg_index 0 = image width, 1 = image height, written when idle
// a write is answered in the cycle after acceptance and the next command may
//   follow at once, so writes run at one per cycle while the output is not stalled
// a read is answered from S_RD, since the pixel memory read port is registered
// a fill reads and tests each pixel visited along each row walk and pops the
//   segments from the stack one by one; its length follows the image content,
//   bounded by the number of pixels tested through the single pixel read port
// input is stalled for the whole of a read or fill
// reset clears the controller and the size registers (32 x 32); pixel and
//   segment memories are not cleared, unwritten pixels read back as junk
// a stalled result holds in the output register; one new command may still be
//   taken while it waits only if it is the same cycle the result leaves
`default_nettype none
module scanline_seed_fill (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [ssf_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                command,
	input  wire logic [ssf_pkg::X_W-1:0]   pos_x,
	input  wire logic [ssf_pkg::Y_W-1:0]   pos_y,
	input  wire logic [ssf_pkg::PIX_W-1:0] pixel_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [ssf_pkg::PIX_W-1:0] read_value,
	output logic      [ssf_pkg::X_W-1:0]   box_left,
	output logic      [ssf_pkg::Y_W-1:0]   box_top,
	output logic      [ssf_pkg::X_W-1:0]   box_right,
	output logic      [ssf_pkg::Y_W-1:0]   box_bottom,
	output logic                           box_empty,
	output logic                           stack_overflow
);
	// command and status between sequencer and datapath
	ssf_pkg::ssf_cmd_t cmd;
	ssf_pkg::ssf_sts_t sts;

	// sequencer: walks the segment stack and the row scans
	ssf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: pixel memory, segment stack, coordinates, bounding box, result
	ssf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pixel_value    (pixel_value),
		.cmd            (cmd),
		.sts            (sts),
		.read_value     (read_value),
		.box_left       (box_left),
		.box_top        (box_top),
		.box_right      (box_right),
		.box_bottom     (box_bottom),
		.box_empty      (box_empty),
		.stack_overflow (stack_overflow)
	);
endmodule
`default_nettype wire

>>> hw/rtl/ssf_chk.sv
`default_nettype none
module ssf_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [ssf_pkg::X_W-1:0]   box_left,
	input wire logic [ssf_pkg::Y_W-1:0]   box_top,
	input wire logic [ssf_pkg::X_W-1:0]   box_right,
	input wire logic [ssf_pkg::Y_W-1:0]   box_bottom,
	input wire logic                      box_empty,
	input wire logic                      stack_overflow
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && box_empty |-> box_left == '0 && box_top == '0 &&
			box_right == '0 && box_bottom == '0)
		else $error("empty box with nonzero corners");

	a_ovf_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_overflow |-> !box_empty)
		else $error("overflow without any filled pixel");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !box_empty |-> box_left <= box_right && box_top <= box_bottom)
		else $error("box corners out of order");
endmodule

bind scanline_seed_fill ssf_chk u_ssf_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.box_left       (box_left),
	.box_top        (box_top),
	.box_right      (box_right),
	.box_bottom     (box_bottom),
	.box_empty      (box_empty),
	.stack_overflow (stack_overflow)
);
`default_nettype wire
